// ----- src/b2da_pkg.sv -----
package b2da_pkg;

  localparam int VALUE_WIDTH   = 64;
  localparam int BITS_PER_STEP = 2;
  localparam int NUM_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SHIFT_W       = NUM_STEPS * BITS_PER_STEP;
  // Decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1.
  localparam int MAX_DIGITS    = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BCD_W         = 4 * MAX_DIGITS;
  localparam int STEP_CNT_W    = $clog2(NUM_STEPS);
  localparam int DIG_IDX_W     = $clog2(MAX_DIGITS);
  localparam int CHAR_W        = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

  typedef struct packed {
    logic load;
    logic shift;
    logic find;
    logic emit;
  } b2da_cmd_t;

  typedef struct packed {
    logic steps_done;
    logic idx_zero;
  } b2da_stat_t;

  // One double dabble step: correct every digit of five or more, then shift in one bit.
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

// ----- src/b2da_in_if.sv -----
interface b2da_in_if;
  import b2da_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- src/b2da_out_if.sv -----
interface b2da_out_if;
  import b2da_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- src/b2da_ctrl.sv -----
module b2da_ctrl
  import b2da_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  b2da_stat_t stat,
  output b2da_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_FIND = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       space;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign space     = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (stat.steps_done) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (space) begin
          cmd.emit = 1'b1;
          if (stat.idx_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/b2da_dp.sv -----
module b2da_dp
  import b2da_pkg::*;
(
  input  logic                   clk,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  b2da_cmd_t              cmd,
  output b2da_stat_t             stat,
  output logic [CHAR_W-1:0]      digit_char,
  output logic                   last_digit
);

  logic [SHIFT_W-1:0]    bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIG_IDX_W-1:0]  idx_r, idx_nxt;
  logic [CHAR_W-1:0]     char_r, char_nxt;
  logic                  last_r, last_nxt;
  logic [3:0]            digits [MAX_DIGITS];
  logic [DIG_IDX_W-1:0]  top_idx;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digits[i] = bcd_r[4*i +: 4];
    end
  end

  // Highest nonzero digit; zero when the whole value is zero.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        top_idx = DIG_IDX_W'(i);
      end
    end
  end

  assign stat.steps_done = (cnt_r == '0);
  assign stat.idx_zero   = (idx_r == '0);

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (cmd.load) begin
      bin_nxt = SHIFT_W'(in_value) << (SHIFT_W - VALUE_WIDTH);
      bcd_nxt = '0;
      cnt_nxt = STEP_CNT_W'(NUM_STEPS - 1);
    end
    if (cmd.shift) begin
      bcd_nxt = dabble(dabble(bcd_r, bin_r[SHIFT_W-1]), bin_r[SHIFT_W-2]);
      bin_nxt = bin_r << BITS_PER_STEP;
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cmd.find) begin
      idx_nxt = top_idx;
    end
    if (cmd.emit) begin
      char_nxt = ASCII_ZERO + CHAR_W'(digits[idx_r]);
      last_nxt = (idx_r == '0);
      idx_nxt  = idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign digit_char = char_r;
  assign last_digit = last_r;

endmodule

// ----- src/binary_to_decimal_ascii.sv -----
// Converts one unsigned binary value to decimal ASCII digits, most significant first.
// Once a value is accepted, 32 double dabble steps of two bits each run; the leading digit
// is then located and loaded into the output register as the first digit word.
// One digit per cycle while the receiver takes them; a new value only after the last digit.
// Reset (rst_n low, synchronous) returns the controller to idle and drops out valid.
module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  b2da_in_if.sink      in_if,
  b2da_out_if.source   out_if
);

  b2da_cmd_t  cmd;
  b2da_stat_t stat;

  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  b2da_dp u_dp (
    .clk        (clk),
    .in_value   (in_if.value),
    .cmd        (cmd),
    .stat       (stat),
    .digit_char (out_if.digit_char),
    .last_digit (out_if.last_digit)
  );

endmodule

// ----- src/b2da_checker.sv -----
module b2da_checker
  import b2da_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_digit_char,
  input logic              out_last_digit
);

  // A stalled word must hold its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char) && $stable(out_last_digit))
    else $error("output word changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= ASCII_ZERO) && (out_digit_char <= ASCII_NINE))
    else $error("output is not a decimal digit");

  // The converter works on one value at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while conversion in progress");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_digit_char (out_if.digit_char),
  .out_last_digit (out_if.last_digit)
);

// ----- tb/binary_to_decimal_ascii_tb.sv -----
module binary_to_decimal_ascii_tb;
  import b2da_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 330;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_word_t;

  class digit_scoreboard;
    digit_word_t expected_words[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    task report(input string msg);
      if (errors < MAX_PRINTS) begin
        $display("%0t: mismatch: %s", $time, msg);
      end
      errors++;
    endtask

    // Splits the value into decimal digits and queues one word per digit, leading digit first.
    function void note_value(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] rest;
      logic [3:0]             decimals[$];
      digit_word_t            word;
      rest = value;
      do begin
        decimals.push_front(4'(rest % VALUE_WIDTH'(10)));
        rest = rest / VALUE_WIDTH'(10);
      end while (rest != '0);
      foreach (decimals[i]) begin
        word.digit_char = ASCII_ZERO + CHAR_W'(decimals[i]);
        word.last_digit = (i == decimals.size() - 1);
        expected_words.push_back(word);
      end
    endfunction

    task check_word(input logic [CHAR_W-1:0] digit_char, input logic last_digit);
      digit_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("digit word 0x%0h last=%0b with nothing expected",
                         digit_char, last_digit));
      end else begin
        want = expected_words.pop_front();
        if (digit_char !== want.digit_char) begin
          report($sformatf("digit_char 0x%0h, expected 0x%0h", digit_char, want.digit_char));
        end
        if (last_digit !== want.last_digit) begin
          report($sformatf("last_digit %0b, expected %0b", last_digit, want.last_digit));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   sent_count = 0;
  logic calm = 1'b0;
  logic hold_off = 1'b0;

  digit_scoreboard sb = new();

  b2da_in_if  in_ch();
  b2da_out_if out_ch();

  binary_to_decimal_ascii dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task send_value(input logic [VALUE_WIDTH-1:0] value);
    // Calm window: no gaps from the sender and no stalls from the receiver.
    calm <= (sent_count >= 150 && sent_count < 220);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= {$urandom, $urandom};
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    sb.note_value(value);
    sent_count++;
  endtask

  // Random values spread over every digit count, plus values around powers of ten.
  task send_random_value();
    logic [VALUE_WIDTH-1:0] value;
    int                     pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      value = VALUE_WIDTH'($urandom_range(0, 20));
    end else if (pick < 22) begin
      value = VALUE_WIDTH'(1);
      repeat ($urandom_range(1, 19)) value = value * VALUE_WIDTH'(10);
      value = value + VALUE_WIDTH'($urandom_range(0, 2)) - VALUE_WIDTH'(1);
    end else if (pick < 35) begin
      value = {$urandom, $urandom};
    end else begin
      value = {$urandom, $urandom} >> $urandom_range(0, 63);
    end
    send_value(value);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'd10000000000000000000);
    send_value(64'd9999999999999999999);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'd12345678901234567890);
    send_value(64'd1234567890123456789);
    send_value(64'd1000000000);
    send_value(64'd4294967295);
    send_value(64'd4294967296);
    send_value(64'd90909090909090909);

    repeat (RANDOM_ITEMS) send_random_value();
    in_ch.valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_word(out_ch.digit_char, out_ch.last_digit);
      end
      out_ch.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 26);
    end
  end

  // A long receiver stall once the run is under way, so the block backs up into its input.
  initial begin
    wait (sent_count >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

endmodule

// ----- sim.f -----
src/b2da_pkg.sv
src/b2da_in_if.sv
src/b2da_out_if.sv
src/b2da_ctrl.sv
src/b2da_dp.sv
src/binary_to_decimal_ascii.sv
src/b2da_checker.sv
tb/binary_to_decimal_ascii_tb.sv
